// File: rtl/chc_pkg.sv
package chc_pkg;

    // Sample and CORDIC datapath sizes.
    localparam int SAMPLE_WIDTH    = 16;
    localparam int DIFF_WIDTH      = SAMPLE_WIDTH + 1;
    localparam int PRESCALE_SHIFT  = 14;
    localparam int GUARD_BITS      = 3;
    localparam int CORDIC_W        = DIFF_WIDTH + PRESCALE_SHIFT + GUARD_BITS;
    localparam int ANGLE_W         = 32;
    localparam int HEADING_W       = 12;
    localparam int COUNT_W         = 12;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam int ANGLE_TABLE_LEN = 24;

    // Reset value of the calibration sample count register.
    localparam logic [COUNT_W-1:0] CAL_SAMPLES_RESET = COUNT_W'(500);

    // Heading scale and the fixed answers on the axes.
    localparam logic [HEADING_W-1:0] TENTHS_PER_TURN = HEADING_W'(3600);
    localparam logic [HEADING_W-1:0] HEADING_NORTH   = HEADING_W'(0);
    localparam logic [HEADING_W-1:0] HEADING_EAST    = HEADING_W'(900);
    localparam logic [HEADING_W-1:0] HEADING_SOUTH   = HEADING_W'(1800);
    localparam logic [HEADING_W-1:0] HEADING_WEST    = HEADING_W'(2700);
    localparam logic [ANGLE_W-1:0]   HALF_TURN       = 32'h8000_0000;

    // Extrema values after a clear.
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Request codes.
    typedef enum logic [1:0] {
        REQ_HEADING = 2'd0,
        REQ_CAL     = 2'd1,
        REQ_LOAD    = 2'd2
    } req_t;

    typedef struct packed {
        req_t                            req_type;
        logic signed [SAMPLE_WIDTH-1:0]  mag_x;
        logic signed [SAMPLE_WIDTH-1:0]  mag_y;
    } in_item_t;

    typedef struct packed {
        logic [HEADING_W-1:0]            heading_tenths;
        logic                            cal_done;
        logic signed [SAMPLE_WIDTH-1:0]  cur_offset_x;
        logic signed [SAMPLE_WIDTH-1:0]  cur_offset_y;
    } out_item_t;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic                            valid;
        logic signed [CORDIC_W-1:0]      x;
        logic signed [CORDIC_W-1:0]      y;
        logic [ANGLE_W-1:0]              z;
        logic                            fixed;
        logic [HEADING_W-1:0]            fixed_heading;
        logic                            cal_done;
        logic signed [SAMPLE_WIDTH-1:0]  off_x;
        logic signed [SAMPLE_WIDTH-1:0]  off_y;
    } cell_t;

    // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
    function automatic logic [ANGLE_W-1:0] atan_turn(input int unsigned idx);
        logic [ANGLE_W-1:0] t;
        case (idx)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/compass_heading_hard_iron_cal.sv
// Compass heading with hard-iron calibration. Each accepted item gives one
// result item. Offset loads and the calibration sample that completes a
// calibration update the offsets in the cycle they are accepted, so the
// very next item already sees them. Heading requests run through a row of
// CORDIC_ITERS rotation cells followed by a scaling stage; up to
// CORDIC_ITERS + 2 items are in flight, and one item is taken every cycle
// while the result side keeps up. The whole row shifts together, so a
// stalled result holds every stage and s_ready follows m_ready whenever a
// result is waiting. cal_samples may only be written while no item is in
// flight; a value of zero acts like one.
module compass_heading_hard_iron_cal
    import chc_pkg::*;
#(
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    logic [COUNT_W-1:0] cal_samples_reg;
    logic               en;
    logic               accept;
    cell_t              chain [CORDIC_ITERS+1];

    // The row advances whenever the output register is free or being taken.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && s_ready;

    // Calibration sample count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg <= CAL_SAMPLES_RESET;
        end else if (cfg_we) begin
            cal_samples_reg <= cfg_wdata;
        end
    end

    chc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .accept      (accept),
        .item        (s_item),
        .cal_samples (cal_samples_reg),
        .stage       (chain[0])
    );

    // Rotation cells, one per CORDIC step.
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
        chc_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    chc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .din       (chain[CORDIC_ITERS]),
        .out_valid (m_valid),
        .out_item  (m_item)
    );

    // A stalled result blocks new items.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    // Headings stay inside one turn.
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.heading_tenths < TENTHS_PER_TURN))
        else $error("heading out of range");

    // A completed calibration never carries a heading.
    a_done_no_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.cal_done) |-> (m_item.heading_tenths == HEADING_NORTH))
        else $error("calibration result with nonzero heading");

    // A result held by the sink keeps its value in the next cycle.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result changed");

endmodule

// File: rtl/chc_front.sv
module chc_front
    import chc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               accept,
    input  in_item_t           item,
    input  logic [COUNT_W-1:0] cal_samples,
    output cell_t              stage
);

    logic signed [SAMPLE_WIDTH-1:0] x_min_reg, x_min_next;
    logic signed [SAMPLE_WIDTH-1:0] x_max_reg, x_max_next;
    logic signed [SAMPLE_WIDTH-1:0] y_min_reg, y_min_next;
    logic signed [SAMPLE_WIDTH-1:0] y_max_reg, y_max_next;
    logic signed [SAMPLE_WIDTH-1:0] off_x_reg, off_x_next;
    logic signed [SAMPLE_WIDTH-1:0] off_y_reg, off_y_next;
    logic [COUNT_W-1:0]             count_reg, count_next;
    cell_t                          stage_reg, stage_next;

    logic signed [SAMPLE_WIDTH-1:0] upd_x_min, upd_x_max, upd_y_min, upd_y_max;
    logic signed [DIFF_WIDTH-1:0]   sum_x, sum_y;
    logic [COUNT_W-1:0]             count_inc;
    logic                           done;
    logic signed [DIFF_WIDTH-1:0]   dx, dy;
    logic signed [CORDIC_W-1:0]     px, py;

    // Extrema including this sample, and the midpoints they give.
    always_comb begin
        upd_x_min = (item.mag_x < x_min_reg) ? item.mag_x : x_min_reg;
        upd_x_max = (item.mag_x > x_max_reg) ? item.mag_x : x_max_reg;
        upd_y_min = (item.mag_y < y_min_reg) ? item.mag_y : y_min_reg;
        upd_y_max = (item.mag_y > y_max_reg) ? item.mag_y : y_max_reg;
        sum_x     = DIFF_WIDTH'(upd_x_max) + DIFF_WIDTH'(upd_x_min);
        sum_y     = DIFF_WIDTH'(upd_y_max) + DIFF_WIDTH'(upd_y_min);
        count_inc = count_reg + COUNT_W'(1);
        done      = (count_inc >= cal_samples);
    end

    // Calibration and offset state update for an accepted item.
    always_comb begin
        x_min_next = x_min_reg;
        x_max_next = x_max_reg;
        y_min_next = y_min_reg;
        y_max_next = y_max_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        count_next = count_reg;
        if (accept) begin
            case (item.req_type)
                REQ_CAL: begin
                    if (done) begin
                        off_x_next = sum_x[DIFF_WIDTH-1:1];
                        off_y_next = sum_y[DIFF_WIDTH-1:1];
                        x_min_next = SAMPLE_MAX;
                        y_min_next = SAMPLE_MAX;
                        x_max_next = SAMPLE_MIN;
                        y_max_next = SAMPLE_MIN;
                        count_next = '0;
                    end else begin
                        x_min_next = upd_x_min;
                        x_max_next = upd_x_max;
                        y_min_next = upd_y_min;
                        y_max_next = upd_y_max;
                        count_next = count_inc;
                    end
                end
                REQ_LOAD: begin
                    off_x_next = item.mag_x;
                    off_y_next = item.mag_y;
                end
                default: begin
                end
            endcase
        end
    end

    // Offset-corrected vector, prescaled and folded into the right half plane.
    always_comb begin
        dx = DIFF_WIDTH'(item.mag_x) - DIFF_WIDTH'(off_x_reg);
        dy = DIFF_WIDTH'(item.mag_y) - DIFF_WIDTH'(off_y_reg);
        px = {{GUARD_BITS{dy[DIFF_WIDTH-1]}}, dy, {PRESCALE_SHIFT{1'b0}}};
        py = {{GUARD_BITS{dx[DIFF_WIDTH-1]}}, dx, {PRESCALE_SHIFT{1'b0}}};

        stage_next          = stage_reg;
        stage_next.valid    = accept;
        stage_next.cal_done = (item.req_type == REQ_CAL) && done;
        stage_next.off_x    = off_x_next;
        stage_next.off_y    = off_y_next;
        if (dy < 0) begin
            stage_next.x = -px;
            stage_next.y = -py;
            stage_next.z = HALF_TURN;
        end else begin
            stage_next.x = px;
            stage_next.y = py;
            stage_next.z = '0;
        end
        // Axis cases and non-heading items bypass the CORDIC result.
        stage_next.fixed         = 1'b1;
        stage_next.fixed_heading = HEADING_NORTH;
        if (item.req_type == REQ_HEADING) begin
            if (dx == 0) begin
                stage_next.fixed_heading = (dy < 0) ? HEADING_SOUTH : HEADING_NORTH;
            end else if (dy == 0) begin
                stage_next.fixed_heading = (dx > 0) ? HEADING_EAST : HEADING_WEST;
            end else begin
                stage_next.fixed = 1'b0;
            end
        end
    end

    // Control state resets; the stage payload does not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg       <= SAMPLE_MAX;
            x_max_reg       <= SAMPLE_MIN;
            y_min_reg       <= SAMPLE_MAX;
            y_max_reg       <= SAMPLE_MIN;
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            count_reg       <= '0;
            stage_reg.valid <= 1'b0;
        end else begin
            x_min_reg <= x_min_next;
            x_max_reg <= x_max_next;
            y_min_reg <= y_min_next;
            y_max_reg <= y_max_next;
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
            count_reg <= count_next;
            if (en) begin
                stage_reg.valid <= stage_next.valid;
            end
        end
        if (en) begin
            stage_reg.x             <= stage_next.x;
            stage_reg.y             <= stage_next.y;
            stage_reg.z             <= stage_next.z;
            stage_reg.fixed         <= stage_next.fixed;
            stage_reg.fixed_heading <= stage_next.fixed_heading;
            stage_reg.cal_done      <= stage_next.cal_done;
            stage_reg.off_x         <= stage_next.off_x;
            stage_reg.off_y         <= stage_next.off_y;
        end
    end

    assign stage = stage_reg;

endmodule

// File: rtl/chc_cell.sv
module chc_cell
    import chc_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t din,
    output cell_t dout
);

    localparam logic [ANGLE_W-1:0] STEP_ANGLE = atan_turn(SHIFT);

    cell_t cell_reg, cell_next;

    // One vectoring rotation, driving y toward zero.
    always_comb begin
        cell_next = din;
        if (din.y >= 0) begin
            cell_next.x = din.x + (din.y >>> SHIFT);
            cell_next.y = din.y - (din.x >>> SHIFT);
            cell_next.z = din.z + STEP_ANGLE;
        end else begin
            cell_next.x = din.x - (din.y >>> SHIFT);
            cell_next.y = din.y + (din.x >>> SHIFT);
            cell_next.z = din.z - STEP_ANGLE;
        end
    end

    // Only the valid flag is reset; the payload just follows the row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (en) begin
            cell_reg.x             <= cell_next.x;
            cell_reg.y             <= cell_next.y;
            cell_reg.z             <= cell_next.z;
            cell_reg.fixed         <= cell_next.fixed;
            cell_reg.fixed_heading <= cell_next.fixed_heading;
            cell_reg.cal_done      <= cell_next.cal_done;
            cell_reg.off_x         <= cell_next.off_x;
            cell_reg.off_y         <= cell_next.off_y;
        end
    end

    assign dout = cell_reg;

endmodule

// File: rtl/chc_scale.sv
module chc_scale
    import chc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  cell_t     din,
    output logic      out_valid,
    output out_item_t out_item
);

    localparam int PROD_W = ANGLE_W + HEADING_W;

    logic [PROD_W-1:0] product;
    out_item_t         item_reg, item_next;
    logic              valid_reg;

    // Turn fraction times 3600, keeping the integer part.
    always_comb begin
        product = PROD_W'(din.z) * PROD_W'(TENTHS_PER_TURN);
        item_next.heading_tenths = din.fixed ? din.fixed_heading
                                             : product[PROD_W-1:ANGLE_W];
        item_next.cal_done       = din.cal_done;
        item_next.cur_offset_x   = din.off_x;
        item_next.cur_offset_y   = din.off_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
